@@ hw/rtl/crcfu_pkg.sv @@
package crcfu_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    typedef enum logic [1:0] {
        CMD_ECHO    = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_VERDICT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [15:0] crc;
        logic        match;
        logic        too_short;
    } cmd_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/crcfu_front.sv @@
module crcfu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic             cfg_write_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       frame_byte,
    input  logic             end_of_frame,
    input  logic             fifo_full,
    output logic             push,
    output crcfu_pkg::cmd_t  cmd
);

    logic        mode_reg, mode_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        accept;
    logic [15:0] fed;
    logic [15:0] chk_crc;
    logic [7:0]  h0n, h1n;
    logic [1:0]  cntn;
    logic        short_frame;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign fed      = crcfu_pkg::crc_feed(crc_reg, mode_reg ? held0_reg : frame_byte);

    always_comb
    begin
        h0n     = held0_reg;
        h1n     = held1_reg;
        chk_crc = crc_reg;
        cntn    = cnt_reg + 2'd1;
        if (cnt_reg[1])
        begin
            chk_crc = fed;
            h0n     = held1_reg;
            h1n     = frame_byte;
            cntn    = 2'd2;
        end
        else if (cnt_reg[0])
        begin
            h1n = frame_byte;
        end
        else
        begin
            h0n = frame_byte;
        end
        short_frame = !cntn[1];
    end

    always_comb
    begin
        mode_next      = mode_reg;
        crc_next       = crc_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        cnt_next       = cnt_reg;
        push           = 1'b0;
        cmd.kind       = crcfu_pkg::CMD_ECHO;
        cmd.data       = frame_byte;
        cmd.crc        = fed;
        cmd.match      = 1'b0;
        cmd.too_short  = 1'b0;
        if (cfg_write_en)
        begin
            mode_next = cfg_write_data;
            crc_next  = crcfu_pkg::CRC_START;
            cnt_next  = 2'd0;
        end
        else if (accept)
        begin
            if (!mode_reg)
            begin
                push     = 1'b1;
                cmd.kind = end_of_frame ? crcfu_pkg::CMD_APPEND : crcfu_pkg::CMD_ECHO;
                crc_next = end_of_frame ? crcfu_pkg::CRC_START : fed;
                cnt_next = end_of_frame ? 2'd0 : cnt_reg;
            end
            else
            begin
                held0_next = h0n;
                held1_next = h1n;
                if (end_of_frame)
                begin
                    push          = 1'b1;
                    cmd.kind      = crcfu_pkg::CMD_VERDICT;
                    cmd.crc       = chk_crc;
                    cmd.too_short = short_frame;
                    cmd.match     = !short_frame && ({h1n, h0n} == chk_crc);
                    crc_next      = crcfu_pkg::CRC_START;
                    cnt_next      = 2'd0;
                end
                else
                begin
                    crc_next = chk_crc;
                    cnt_next = cntn;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            crc_reg   <= crcfu_pkg::CRC_START;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("held count out of range");

    a_check_push_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (push && mode_reg) |-> (end_of_frame && cmd.kind == crcfu_pkg::CMD_VERDICT))
        else $error("check mode pushed without frame end");

endmodule

@@ hw/rtl/crcfu_fifo.sv @@
module crcfu_fifo #(
    parameter int DEPTH = crcfu_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crcfu_pkg::cmd_t  push_cmd,
    input  logic             pop,
    output crcfu_pkg::cmd_t  pop_cmd,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    crcfu_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

endmodule

@@ hw/rtl/crcfu_back.sv @@
module crcfu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  crcfu_pkg::cmd_t  cmd,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       result_kind,
    output logic             crc_match,
    output logic             frame_too_short,
    output logic [15:0]      crc_value,
    output logic             last_of_run
);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_LO   = 3'b010,
        BK_HI   = 3'b100
    } back_state_t;

    back_state_t phase_reg, phase_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  kind_reg, kind_next;
    logic        match_reg, match_next;
    logic        short_reg, short_next;
    logic [15:0] crc_reg, crc_next;
    logic        last_reg, last_next;
    logic        slot_free;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        match_next = match_reg;
        short_next = short_reg;
        crc_next   = crc_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (slot_free)
        begin
            case (phase_reg)
                BK_LO:
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[7:0];
                    kind_next  = crcfu_pkg::KIND_CRC;
                    match_next = 1'b0;
                    short_next = 1'b0;
                    last_next  = 1'b0;
                    phase_next = BK_HI;
                end
                BK_HI:
                begin
                    valid_next = 1'b1;
                    byte_next  = crc_reg[15:8];
                    kind_next  = crcfu_pkg::KIND_CRC;
                    match_next = 1'b0;
                    short_next = 1'b0;
                    last_next  = 1'b1;
                    phase_next = BK_IDLE;
                end
                default:
                begin
                    phase_next = BK_IDLE;
                    valid_next = !empty;
                    if (!empty)
                    begin
                        pop        = 1'b1;
                        match_next = cmd.match;
                        short_next = cmd.too_short;
                        crc_next   = cmd.crc;
                        if (cmd.kind == crcfu_pkg::CMD_VERDICT)
                        begin
                            byte_next = 8'h00;
                            kind_next = crcfu_pkg::KIND_VERDICT;
                            last_next = 1'b1;
                        end
                        else
                        begin
                            byte_next = cmd.data;
                            kind_next = crcfu_pkg::KIND_DATA;
                            last_next = (cmd.kind != crcfu_pkg::CMD_APPEND);
                            if (cmd.kind == crcfu_pkg::CMD_APPEND)
                            begin
                                phase_next = BK_LO;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        kind_reg  <= kind_next;
        match_reg <= match_next;
        short_reg <= short_next;
        crc_reg   <= crc_next;
        last_reg  <= last_next;
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign result_kind     = kind_reg;
    assign crc_match       = match_reg;
    assign frame_too_short = short_reg;
    assign crc_value       = crc_reg;
    assign last_of_run     = last_reg;

    a_phase_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != BK_IDLE) |-> valid_reg)
        else $error("append expansion without held result");

    a_open_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> (phase_reg != BK_IDLE))
        else $error("open run with no pending CRC byte");

    a_hi_follows_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == BK_HI) |-> (kind_reg == crcfu_pkg::KIND_CRC && !last_reg))
        else $error("CRC high byte not preceded by low byte");

endmodule

@@ hw/rtl/modbus_rtu_crc_frame_unit_top.sv @@
// A result from an accepted byte is written into the command queue, then registered in the output stage.
// Throughput: one byte per cycle while the queue is not full; an append-mode frame end emits three results,
// so the output side sets the pace there, buffered by the command queue (FIFO_DEPTH).
// Check-mode bytes before frame end emit nothing.
// Reset (rst_n, async, active low): append mode, CRC 0xFFFF, queue and output empty.
module modbus_rtu_crc_frame_unit_top #(
    parameter int FIFO_DEPTH = crcfu_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        end_of_frame,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  result_kind,
    output logic        crc_match,
    output logic        frame_too_short,
    output logic [15:0] crc_value,
    output logic        last_of_run
);

    logic            fifo_full;
    logic            fifo_empty;
    logic            push;
    logic            pop;
    crcfu_pkg::cmd_t push_cmd;
    crcfu_pkg::cmd_t pop_cmd;

    crcfu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_byte     (frame_byte),
        .end_of_frame   (end_of_frame),
        .fifo_full      (fifo_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    crcfu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    crcfu_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (fifo_empty),
        .cmd             (pop_cmd),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .result_kind     (result_kind),
        .crc_match       (crc_match),
        .frame_too_short (frame_too_short),
        .crc_value       (crc_value),
        .last_of_run     (last_of_run)
    );

endmodule
